[hdl/wav_header_validator_defines.svh]
// ---------------------------------------------------------------------------
// wav_header_validator_defines
// Assertion macros shared by the RIFF/WAVE checker RTL.
// ---------------------------------------------------------------------------
`ifndef WAV_HEADER_VALIDATOR_DEFINES_SVH
`define WAV_HEADER_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define WAVV_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define WAVV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wavv_pkg.sv]
// ---------------------------------------------------------------------------
// wavv_pkg
// Types, tags and codes shared by the RIFF/WAVE format checker.
// ---------------------------------------------------------------------------
`default_nettype none

package wavv_pkg;

  // Default chunk size width
  localparam int SIZE_WIDTH_DEF = 32;

  // Chunk and file tags, first byte in the top lane
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Format tags
  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_ALAW  = 16'h0006;
  localparam logic [15:0] FMT_MULAW = 16'h0007;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;

  // Extensible layout limits
  localparam logic [15:0] EXT_CB_MIN    = 16'd22;
  localparam logic [5:0]  EXT_LAST_OFF  = 6'd39;  // offset of the 40th body byte
  localparam logic [5:0]  GUID_FIRST    = 6'd26;
  localparam logic [5:0]  FMT_MIN_LEN   = 6'd16;
  localparam logic [5:0]  IDX_MAX       = 6'd63;

  // Fixed tail of the subformat GUID, body offsets 26 to 39
  localparam logic [7:0] GUID_TAIL [14] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h80, 8'h00,
    8'h00, 8'hAA, 8'h00, 8'h38, 8'h9B, 8'h71
  };

  // Verdict codes
  localparam logic [2:0] FAIL_NONE    = 3'd0;
  localparam logic [2:0] FAIL_FORM    = 3'd1;
  localparam logic [2:0] FAIL_OVERRUN = 3'd2;
  localparam logic [2:0] FAIL_EXT     = 3'd3;
  localparam logic [2:0] FAIL_ZERO    = 3'd4;
  localparam logic [2:0] FAIL_UNSUP   = 3'd5;
  localparam logic [2:0] FAIL_NODATA  = 3'd6;

  // Parser phases
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_HEADER,
    PH_BODY,
    PH_PAD,
    PH_HALT
  } phase_t;

  // Parser to fmt unit controls
  typedef struct packed {
    logic       clear;      // end of file, back to reset values
    logic       fmt_clear;  // fmt chunk header done, clear fields
    logic       cap_en;     // fmt body byte present
    logic       commit_en;  // fmt chunk ends on this byte
    logic [5:0] off;        // body offset of this byte
    logic [7:0] data;
  } fmt_ctrl_t;

  // Fmt unit to parser status
  typedef struct packed {
    logic ext_fail;   // extensible layout check fails
    logic zero_fail;  // zero channels or zero rate
    logic supported;  // support flag after this byte
  } fmt_stat_t;

endpackage

`default_nettype wire

[hdl/wavv_if.sv]
// ---------------------------------------------------------------------------
// wavv_if
// Valid/ready channels: file bytes in, verdicts out.
// ---------------------------------------------------------------------------
`default_nettype none

interface wavv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface wavv_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] fail_reason;

  modport source (output valid, output accepted, output fail_reason, input ready);
  modport sink   (input valid, input accepted, input fail_reason, output ready);
endinterface

`default_nettype wire

[hdl/wav_header_validator.sv]
// ---------------------------------------------------------------------------
// wav_header_validator
// Byte-stream RIFF/WAVE checker: walks chunks, checks the fmt chunk and
// gives one verdict on the last byte of each file.
// ---------------------------------------------------------------------------
//   Channel  Dir  Payload                       Transfer
//   in_ch    in   byte_value[8], final_byte[1]  valid & ready
//   out_ch   out  accepted[1], fail_reason[3]   valid & ready
//
// One byte per cycle; every byte is parsed in the cycle it transfers.
// The verdict is registered and appears in the cycle after the final byte
// and sits in the output register until taken; in_ch stalls only while
// that register is full and out_ch.ready is low. Reset is synchronous;
// after each verdict the parser starts a new file.
// ---------------------------------------------------------------------------
`default_nettype none
`include "wav_header_validator_defines.svh"

module wav_header_validator
  import wavv_pkg::*;
#(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wavv_in_if.sink     in_ch,
  wavv_out_if.source  out_ch
);

  localparam logic [32:0] SIZE_LIM = 33'(1) << SIZE_WIDTH;
  localparam logic [31:0] HI_MASK  = ~(SIZE_LIM[31:0] - 32'd1);

  phase_t                phase_r, phase_nxt;
  logic [5:0]            idx_r,   idx_nxt;
  logic [31:0]           tag_r,   tag_nxt;
  logic [SIZE_WIDTH-1:0] rem_r,   rem_nxt;
  logic                  odd_r,   odd_nxt;
  logic                  over_r,  over_nxt;
  logic                  audio_r, audio_nxt;
  logic [2:0]            fail_r,  fail_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_acc_r;
  logic [2:0]            out_reason_r;

  logic                  in_fire;
  logic                  last;
  logic [5:0]            idx_inc;
  logic [31:0]           lane;
  logic [2:0]            reason;
  fmt_ctrl_t             fctl;
  fmt_stat_t             fstat;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign last        = in_ch.final_byte;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.fail_reason = out_reason_r;

  wavv_fmt_unit u_fmt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fctl),
    .stat  (fstat)
  );

  // Parse one byte: phase walk, chunk bookkeeping, verdict
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    odd_nxt   = odd_r;
    over_nxt  = over_r;
    audio_nxt = audio_r;
    fail_nxt  = fail_r;
    idx_inc   = idx_r + 6'd1;
    lane      = 32'(in_ch.byte_value) << {idx_r[1:0], 3'b000};
    fctl      = '0;
    fctl.off  = idx_r;
    fctl.data = in_ch.byte_value;

    unique case (phase_r)
      PH_PREFIX: begin
        tag_nxt = {tag_r[23:0], in_ch.byte_value};
        idx_nxt = idx_inc;
        if (idx_inc == 6'd4 && tag_nxt != TAG_RIFF) begin
          fail_nxt  = FAIL_FORM;
          phase_nxt = PH_HALT;
        end else if (idx_inc == 6'd12) begin
          if (tag_nxt != TAG_WAVE) begin
            fail_nxt  = FAIL_FORM;
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_HEADER;
            idx_nxt   = '0;
            tag_nxt   = '0;
            rem_nxt   = '0;
          end
        end
      end
      PH_HEADER: begin
        if (idx_r < 6'd4) begin
          tag_nxt = {tag_r[23:0], in_ch.byte_value};
        end else begin
          rem_nxt  = rem_r | lane[SIZE_WIDTH-1:0];
          over_nxt = over_r | (|(lane & HI_MASK));
        end
        idx_nxt = idx_inc;
        // Header complete: size check, then enter the body, or the next header if the chunk is empty
        if (idx_inc >= 6'd8) begin
          idx_nxt  = '0;
          odd_nxt  = rem_nxt[0];
          over_nxt = 1'b0;
          if (over_r || (|(lane & HI_MASK))) begin
            fail_nxt  = FAIL_OVERRUN;
            phase_nxt = PH_HALT;
          end else begin
            fctl.fmt_clear = (tag_r == TAG_FMT);
            if (tag_r == TAG_DATA && rem_nxt != '0) begin
              audio_nxt = 1'b1;
            end
            phase_nxt = PH_BODY;
            if (rem_nxt == '0) begin
              phase_nxt = PH_HEADER;
              tag_nxt   = '0;
            end
          end
        end
      end
      PH_BODY: begin
        fctl.cap_en = (tag_r == TAG_FMT);
        idx_nxt     = (idx_r == IDX_MAX) ? idx_r : idx_inc;
        rem_nxt     = rem_r - SIZE_WIDTH'(1);
        // Chunk end: commit fmt, then halt on a failure, else pad or next header
        if (rem_nxt == '0) begin
          fctl.commit_en = (tag_r == TAG_FMT) && (idx_nxt >= FMT_MIN_LEN);
          if (fctl.commit_en && (fstat.ext_fail || fstat.zero_fail)) begin
            fail_nxt  = fstat.ext_fail ? FAIL_EXT : FAIL_ZERO;
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = odd_r ? PH_PAD : PH_HEADER;
            idx_nxt   = '0;
            tag_nxt   = '0;
          end
        end
      end
      PH_PAD: begin
        phase_nxt = PH_HEADER;
        idx_nxt   = '0;
      end
      PH_HALT: begin
      end
      default: begin
      end
    endcase

    // Verdict from the state after this byte
    if (fail_nxt != FAIL_NONE) begin
      reason = fail_nxt;
    end else if (phase_nxt == PH_PREFIX) begin
      reason = FAIL_FORM;
    end else if (phase_nxt == PH_BODY && rem_nxt != '0) begin
      reason = FAIL_OVERRUN;
    end else if (!fstat.supported) begin
      reason = FAIL_UNSUP;
    end else if (!audio_nxt) begin
      reason = FAIL_NODATA;
    end else begin
      reason = FAIL_NONE;
    end

    // Drop all parse state after the last byte
    if (last) begin
      phase_nxt  = PH_PREFIX;
      idx_nxt    = '0;
      tag_nxt    = '0;
      rem_nxt    = '0;
      odd_nxt    = 1'b0;
      over_nxt   = 1'b0;
      audio_nxt  = 1'b0;
      fail_nxt   = FAIL_NONE;
      fctl.clear = 1'b1;
    end

    // Only a transfer moves the fmt unit
    if (!in_fire) begin
      fctl.clear     = 1'b0;
      fctl.fmt_clear = 1'b0;
      fctl.cap_en    = 1'b0;
      fctl.commit_en = 1'b0;
    end

    // Output register: load on last byte, release on transfer
    if (in_fire && last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      idx_r   <= '0;
      tag_r   <= '0;
      rem_r   <= '0;
      odd_r   <= 1'b0;
      over_r  <= 1'b0;
      audio_r <= 1'b0;
      fail_r  <= FAIL_NONE;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
      odd_r   <= odd_nxt;
      over_r  <= over_nxt;
      audio_r <= audio_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      out_acc_r    <= (reason == FAIL_NONE);
      out_reason_r <= reason;
    end
  end

  `WAVV_ASSERT_IMPL(a_stall_blocks_in, out_valid_r && !out_ch.ready, !in_ch.ready,
    "input taken while a verdict is blocked")
  `WAVV_ASSERT_IMPL(a_verdict_agree, out_valid_r, out_acc_r == (out_reason_r == FAIL_NONE),
    "accepted flag disagrees with fail reason")
  `WAVV_ASSERT_IMPL(a_halt_has_code, phase_r == PH_HALT, fail_r != FAIL_NONE,
    "halted parser without a failure code")
  `WAVV_ASSERT_IMPL(a_body_nonempty, phase_r == PH_BODY, rem_r != '0,
    "chunk body phase with nothing remaining")
  `WAVV_ASSERT_NEXT(a_last_gives_verdict, in_fire && last, out_valid_r && phase_r == PH_PREFIX,
    "last byte did not load a verdict and restart")

endmodule

`default_nettype wire

[hdl/wavv_fmt_unit.sv]
// ---------------------------------------------------------------------------
// wavv_fmt_unit
// Captures fmt chunk fields byte by byte and evaluates them at chunk end.
// ---------------------------------------------------------------------------
`default_nettype none

module wavv_fmt_unit
  import wavv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fmt_ctrl_t ctrl,
  output fmt_stat_t      stat
);

  logic [15:0] fmt_tag_r,  fmt_tag_nxt;
  logic [15:0] chan_r,     chan_nxt;
  logic [31:0] rate_r,     rate_nxt;
  logic [15:0] bits_r,     bits_nxt;
  logic [15:0] cb_r,       cb_nxt;
  logic [15:0] sub_r,      sub_nxt;
  logic        guid_ok_r,  guid_ok_nxt;
  logic        sup_r,      sup_nxt;

  logic [3:0]  gidx;
  logic        is_ext;
  logic [15:0] eff_fmt;
  logic        sup_calc;

  // Clear on fmt_clear, else capture the current byte into its field lane or check it against the GUID tail
  always_comb begin
    fmt_tag_nxt = fmt_tag_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    cb_nxt      = cb_r;
    sub_nxt     = sub_r;
    guid_ok_nxt = guid_ok_r;
    gidx        = 4'(ctrl.off - GUID_FIRST);
    if (ctrl.fmt_clear) begin
      fmt_tag_nxt = '0;
      chan_nxt    = '0;
      rate_nxt    = '0;
      bits_nxt    = '0;
      cb_nxt      = '0;
      sub_nxt     = '0;
      guid_ok_nxt = 1'b1;
    end else if (ctrl.cap_en) begin
      case (ctrl.off)
        6'd0:  fmt_tag_nxt[7:0]  = ctrl.data;
        6'd1:  fmt_tag_nxt[15:8] = ctrl.data;
        6'd2:  chan_nxt[7:0]     = ctrl.data;
        6'd3:  chan_nxt[15:8]    = ctrl.data;
        6'd4:  rate_nxt[7:0]     = ctrl.data;
        6'd5:  rate_nxt[15:8]    = ctrl.data;
        6'd6:  rate_nxt[23:16]   = ctrl.data;
        6'd7:  rate_nxt[31:24]   = ctrl.data;
        6'd14: bits_nxt[7:0]     = ctrl.data;
        6'd15: bits_nxt[15:8]    = ctrl.data;
        6'd16: cb_nxt[7:0]       = ctrl.data;
        6'd17: cb_nxt[15:8]      = ctrl.data;
        6'd24: sub_nxt[7:0]      = ctrl.data;
        6'd25: sub_nxt[15:8]     = ctrl.data;
        default: begin
          if (ctrl.off >= GUID_FIRST && ctrl.off <= EXT_LAST_OFF &&
              ctrl.data != GUID_TAIL[gidx]) begin
            guid_ok_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // Evaluate the fields as they stand after this byte
  always_comb begin
    is_ext   = (fmt_tag_nxt == FMT_EXT);
    stat.ext_fail = is_ext &&
                    (ctrl.off < EXT_LAST_OFF || cb_nxt < EXT_CB_MIN || !guid_ok_nxt);
    stat.zero_fail = (chan_nxt == '0) || (rate_nxt == '0);
    eff_fmt  = is_ext ? sub_nxt : fmt_tag_nxt;
    sup_calc = (eff_fmt == FMT_PCM &&
                (bits_nxt == 16'd8 || bits_nxt == 16'd16 ||
                 bits_nxt == 16'd24 || bits_nxt == 16'd32)) ||
               (eff_fmt == FMT_FLOAT && (bits_nxt == 16'd32 || bits_nxt == 16'd64)) ||
               ((eff_fmt == FMT_ALAW || eff_fmt == FMT_MULAW) && bits_nxt == 16'd8);
    sup_nxt  = (ctrl.commit_en && !stat.ext_fail && !stat.zero_fail) ? sup_calc : sup_r;
    stat.supported = sup_nxt;
  end

  // Hold fields; return to reset values at end of file
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      fmt_tag_r <= '0;
      chan_r    <= '0;
      rate_r    <= '0;
      bits_r    <= '0;
      cb_r      <= '0;
      sub_r     <= '0;
      guid_ok_r <= 1'b1;
      sup_r     <= 1'b0;
    end else begin
      fmt_tag_r <= fmt_tag_nxt;
      chan_r    <= chan_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      cb_r      <= cb_nxt;
      sub_r     <= sub_nxt;
      guid_ok_r <= guid_ok_nxt;
      sup_r     <= sup_nxt;
    end
  end

endmodule

`default_nettype wire
